>>> src/pcib_pkg.sv
// Shared constants, operation codes and reset images for the PCI bridge configuration space.
`timescale 1ns / 1ps

package pcib_pkg;

  localparam int REG_SPACE_DEPTH = 256;

  typedef enum logic [1:0] {
    OP_CFG_RD = 2'd0,
    OP_CFG_WR = 2'd1,
    OP_RC_RD  = 2'd2,
    OP_RC_WR  = 2'd3
  } op_t;

  localparam logic [2:0] FN_BRIDGE = 3'd0;
  localparam logic [2:0] FN_IDE    = 3'd1;

  // byte offsets that feed the decoded outputs or carry write rules
  localparam logic [7:0] ADDR_CMD     = 8'h04;
  localparam logic [7:0] ADDR_STAT_HI = 8'h07;
  localparam logic [7:0] ADDR_LAT     = 8'h0d;
  localparam logic [7:0] ADDR_BM_LO   = 8'h20;
  localparam logic [7:0] ADDR_BM_HI   = 8'h21;
  localparam logic [7:0] ADDR_TIM0    = 8'h40;
  localparam logic [7:0] ADDR_TIM1    = 8'h41;
  localparam logic [7:0] ADDR_TIM2    = 8'h42;
  localparam logic [7:0] ADDR_TIM3    = 8'h43;
  localparam logic [5:0] ADDR_IRQ_HI  = 6'h18;  // 0x60..0x63 share these upper bits

  localparam logic [7:0] RC_KEEP_MASK = ~8'h04;
  localparam logic [7:0] ABSENT_DATA  = 8'hff;
  localparam logic [4:0] IRQ_OFF      = 5'd16;

  function automatic logic [7:0] bridge_image(input logic [7:0] a);
    logic [7:0] v;
    unique case (a)
      8'h00: v = 8'h86;
      8'h01: v = 8'h80;
      8'h02: v = 8'h2e;
      8'h03: v = 8'h12;
      8'h04: v = 8'h07;
      8'h06: v = 8'h80;
      8'h07: v = 8'h02;
      8'h0a: v = 8'h01;
      8'h0b: v = 8'h06;
      8'h0e: v = 8'h80;
      8'h4c: v = 8'h4d;
      8'h4e: v = 8'h03;
      8'h60: v = 8'h80;
      8'h61: v = 8'h80;
      8'h62: v = 8'h80;
      8'h63: v = 8'h80;
      8'h69: v = 8'h02;
      8'h70: v = 8'h80;
      8'h71: v = 8'h80;
      8'h76: v = 8'h0c;
      8'h77: v = 8'h0c;
      8'h78: v = 8'h02;
      8'ha0: v = 8'h08;
      8'ha8: v = 8'h0f;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] ide_image(input logic [7:0] a);
    logic [7:0] v;
    unique case (a)
      8'h00: v = 8'h86;
      8'h01: v = 8'h80;
      8'h02: v = 8'h30;
      8'h03: v = 8'h12;
      8'h04: v = 8'h02;
      8'h06: v = 8'h80;
      8'h07: v = 8'h02;
      8'h09: v = 8'h80;
      8'h0a: v = 8'h01;
      8'h0b: v = 8'h01;
      8'h20: v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // function 0 bytes that ignore writes
  function automatic logic bridge_read_only(input logic [7:0] a);
    return (a >= 8'h0f && a < 8'h4c) || (a <= 8'h03) ||
           (a >= 8'h08 && a <= 8'h0b) || (a == 8'h0e);
  endfunction

  function automatic logic [4:0] route_of(input logic [7:0] b);
    return b[7] ? IRQ_OFF : {1'b0, b[3:0]};
  endfunction

endpackage

>>> src/pci_bridge_config_space.sv
// Top level: two-function PCI bridge configuration space with a reset-control port.
//
// After reset the block loads the default images of both configuration
// spaces into their RAMs (in_tready stays low meanwhile). From then on the
// byte of an access is read from the function's RAM in the cycle of the beat,
// and in the EXEC state the result is formed and any modified byte written
// back once the output register is free or being emptied. No new access is
// taken until then. A finished result waits in the output register while the
// next access is taken in. Each result carries the byte read together with the
// bus-master, IDE channel and IRQ routing values decoded from the stored bytes
// as they stand after that access.
`timescale 1ns / 1ps

module pci_bridge_config_space #(
  parameter int REG_SPACE_DEPTH = pcib_pkg::REG_SPACE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] pci_function, [10:3] reg_addr, [18:11] write_data
  input  logic [23:0] in_tdata,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [23:8] busmaster_base, [24] busmaster_enable,
  // [25] ide_primary_enable, [26] ide_secondary_enable, [31:27] irq_route_a,
  // [36:32] irq_route_b, [41:37] irq_route_c, [46:42] irq_route_d,
  // [47] soft_reset_pulse, [48] hard_reset_pulse
  output logic [55:0] out_tdata
);

  localparam int AW = $clog2(REG_SPACE_DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // captured beat
  pcib_pkg::op_t op_r;
  logic [2:0]    fn_r;
  logic [7:0]    addr_r;
  logic [7:0]    wdata_r;

  logic [7:0] rc_r, rc_nxt;

  // copies of the bytes behind the decoded outputs
  logic [7:0] ide_cmd_r, ide_bm_lo_r, ide_bm_hi_r, ide_tim1_r, ide_tim3_r;
  logic [7:0] irq_byte_r [4];

  logic        out_tvalid_r;
  logic [55:0] out_tdata_r;

  logic in_fire, commit;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic [7:0] bridge_rdata, ide_rdata;
  logic bridge_we, ide_we;
  logic [7:0] bridge_wdata, ide_wdata;

  logic       ide_wr_hit, bridge_wr_hit;
  logic [7:0] ide_new;
  logic [7:0] read_byte;
  logic       soft_p, hard_p;

  logic [7:0] cmd_post, bm_lo_post, bm_hi_post, tim1_post, tim3_post;
  logic [7:0] irq_post [4];
  logic       bm_en;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign commit    = (state_r == ST_EXEC) && (!out_tvalid_r || out_tready);

  assign ram_raddr = (state_r == ST_IDLE) ? in_tdata[3 +: AW] : addr_r[AW-1:0];
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r[AW-1:0];

  pcib_ram #(.WIDTH(8), .DEPTH(REG_SPACE_DEPTH)) u_bridge_ram (
    .clk   (clk),
    .we    (bridge_we),
    .waddr (ram_waddr),
    .wdata (bridge_wdata),
    .raddr (ram_raddr),
    .rdata (bridge_rdata)
  );

  pcib_ram #(.WIDTH(8), .DEPTH(REG_SPACE_DEPTH)) u_ide_ram (
    .clk   (clk),
    .we    (ide_we),
    .waddr (ram_waddr),
    .wdata (ide_wdata),
    .raddr (ram_raddr),
    .rdata (ide_rdata)
  );

  // IDE write rules, applied to the byte just read back
  always_comb begin
    ide_wr_hit = 1'b1;
    ide_new    = wdata_r;
    unique case (addr_r)
      pcib_pkg::ADDR_CMD:     ide_new = (ide_rdata & 8'hfa) | (wdata_r & 8'h05);
      pcib_pkg::ADDR_STAT_HI: ide_new = (ide_rdata & 8'hc7) | (wdata_r & 8'h38);
      pcib_pkg::ADDR_BM_LO:   ide_new = (wdata_r & 8'hf0) | 8'h01;
      pcib_pkg::ADDR_LAT, pcib_pkg::ADDR_BM_HI, pcib_pkg::ADDR_TIM0,
      pcib_pkg::ADDR_TIM1, pcib_pkg::ADDR_TIM2, pcib_pkg::ADDR_TIM3:
                              ide_new = wdata_r;
      default:                ide_wr_hit = 1'b0;
    endcase
  end

  assign bridge_wr_hit = !pcib_pkg::bridge_read_only(addr_r);

  always_comb begin
    if (state_r == ST_CLEAR) begin
      bridge_we    = 1'b1;
      ide_we       = 1'b1;
      bridge_wdata = pcib_pkg::bridge_image(8'(clr_cnt_r));
      ide_wdata    = pcib_pkg::ide_image(8'(clr_cnt_r));
    end else begin
      bridge_we    = commit && (op_r == pcib_pkg::OP_CFG_WR) &&
                     (fn_r == pcib_pkg::FN_BRIDGE) && bridge_wr_hit;
      ide_we       = commit && (op_r == pcib_pkg::OP_CFG_WR) &&
                     (fn_r == pcib_pkg::FN_IDE) && ide_wr_hit;
      bridge_wdata = wdata_r;
      ide_wdata    = ide_new;
    end
  end

  // values as they stand after this access
  always_comb begin
    cmd_post   = (ide_we && addr_r == pcib_pkg::ADDR_CMD)   ? ide_new : ide_cmd_r;
    bm_lo_post = (ide_we && addr_r == pcib_pkg::ADDR_BM_LO) ? ide_new : ide_bm_lo_r;
    bm_hi_post = (ide_we && addr_r == pcib_pkg::ADDR_BM_HI) ? ide_new : ide_bm_hi_r;
    tim1_post  = (ide_we && addr_r == pcib_pkg::ADDR_TIM1)  ? ide_new : ide_tim1_r;
    tim3_post  = (ide_we && addr_r == pcib_pkg::ADDR_TIM3)  ? ide_new : ide_tim3_r;
    for (int i = 0; i < 4; i++) begin
      irq_post[i] = (bridge_we && addr_r[7:2] == pcib_pkg::ADDR_IRQ_HI &&
                     addr_r[1:0] == 2'(i)) ? wdata_r : irq_byte_r[i];
    end
  end

  assign bm_en = cmd_post[0];

  always_comb begin
    read_byte = 8'h00;
    soft_p    = 1'b0;
    hard_p    = 1'b0;
    rc_nxt    = rc_r;
    unique case (op_r)
      pcib_pkg::OP_CFG_RD: begin
        if (fn_r == pcib_pkg::FN_BRIDGE) begin
          read_byte = bridge_rdata;
        end else if (fn_r == pcib_pkg::FN_IDE) begin
          read_byte = ide_rdata;
        end else begin
          read_byte = pcib_pkg::ABSENT_DATA;
        end
      end
      pcib_pkg::OP_CFG_WR: ;
      pcib_pkg::OP_RC_RD: read_byte = rc_r;
      pcib_pkg::OP_RC_WR: begin
        soft_p = wdata_r[2];
        hard_p = wdata_r[2] && wdata_r[1];
        if (commit) begin
          rc_nxt = wdata_r & pcib_pkg::RC_KEEP_MASK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(REG_SPACE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      rc_r         <= 8'h00;
      out_tvalid_r <= 1'b0;
      ide_cmd_r    <= pcib_pkg::ide_image(pcib_pkg::ADDR_CMD);
      ide_bm_lo_r  <= pcib_pkg::ide_image(pcib_pkg::ADDR_BM_LO);
      ide_bm_hi_r  <= pcib_pkg::ide_image(pcib_pkg::ADDR_BM_HI);
      ide_tim1_r   <= pcib_pkg::ide_image(pcib_pkg::ADDR_TIM1);
      ide_tim3_r   <= pcib_pkg::ide_image(pcib_pkg::ADDR_TIM3);
      for (int i = 0; i < 4; i++) begin
        irq_byte_r[i] <= pcib_pkg::bridge_image({pcib_pkg::ADDR_IRQ_HI, 2'(i)});
      end
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      rc_r      <= rc_nxt;
      if (commit) begin
        out_tvalid_r <= 1'b1;
        ide_cmd_r    <= cmd_post;
        ide_bm_lo_r  <= bm_lo_post;
        ide_bm_hi_r  <= bm_hi_post;
        ide_tim1_r   <= tim1_post;
        ide_tim3_r   <= tim3_post;
        for (int i = 0; i < 4; i++) begin
          irq_byte_r[i] <= irq_post[i];
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= pcib_pkg::op_t'(in_tuser);
      fn_r    <= in_tdata[2:0];
      addr_r  <= in_tdata[10:3];
      wdata_r <= in_tdata[18:11];
    end
    if (commit) begin
      out_tdata_r <= {7'd0, hard_p, soft_p,
                      pcib_pkg::route_of(irq_post[3]), pcib_pkg::route_of(irq_post[2]),
                      pcib_pkg::route_of(irq_post[1]), pcib_pkg::route_of(irq_post[0]),
                      bm_en && tim3_post[7], bm_en && tim1_post[7], bm_en,
                      bm_hi_post, bm_lo_post & 8'hf0, read_byte};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_fire_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EXEC)
    else $error("accepted beat did not start execution");

  a_no_ram_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !bridge_we && !ide_we)
    else $error("RAM written while idle");

  a_hard_needs_soft: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[48] && !out_tdata_r[47]))
    else $error("hard reset pulse without soft reset pulse");

  a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_tvalid_r && state_r == ST_IDLE)
    else $error("committed access left no result");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |=> !out_tvalid_r || $past(out_tvalid_r))
    else $error("result appeared during image load");

endmodule

>>> src/pcib_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pcib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcib_pkg::REG_SPACE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sv/pci_bridge_config_space_tb.sv
// Self-checking bench for the PCI bridge configuration space: directed and random bus accesses.
`timescale 1ns / 1ps

module pci_bridge_config_space_tb;

  localparam int STALL_LIMIT    = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int ITEMS_PER_PHASE = 482;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 10;

  localparam logic [7:0] ADDR_IRQ_A = 8'h60;
  localparam logic [7:0] ADDR_IRQ_B = 8'h61;
  localparam logic [7:0] ADDR_IRQ_C = 8'h62;
  localparam logic [7:0] ADDR_IRQ_D = 8'h63;
  localparam logic [2:0] FN_LAST    = 3'd7;

  typedef struct {
    pcib_pkg::op_t op;
    logic [2:0]    fn;
    logic [7:0]    addr;
    logic [7:0]    wdata;
  } access_t;

  // laid out as out_tdata[48:0], msb first
  typedef struct packed {
    logic        hard_reset;
    logic        soft_reset;
    logic [4:0]  irq_d;
    logic [4:0]  irq_c;
    logic [4:0]  irq_b;
    logic [4:0]  irq_a;
    logic        sec_en;
    logic        pri_en;
    logic        bm_en;
    logic [15:0] bm_base;
    logic [7:0]  read_data;
  } cfg_result_t;

  class cfg_space_scoreboard;
    logic [7:0]  bridge_bytes [256];
    logic [7:0]  ide_bytes [256];
    logic [7:0]  rc_byte;
    cfg_result_t expected_beats [$];
    int          faults;

    function new();
      foreach (bridge_bytes[i]) bridge_bytes[i] = 8'h00;
      foreach (ide_bytes[i]) ide_bytes[i] = 8'h00;
      bridge_bytes[8'h00] = 8'h86; bridge_bytes[8'h01] = 8'h80;
      bridge_bytes[8'h02] = 8'h2e; bridge_bytes[8'h03] = 8'h12;
      bridge_bytes[8'h04] = 8'h07; bridge_bytes[8'h06] = 8'h80;
      bridge_bytes[8'h07] = 8'h02; bridge_bytes[8'h0a] = 8'h01;
      bridge_bytes[8'h0b] = 8'h06; bridge_bytes[8'h0e] = 8'h80;
      bridge_bytes[8'h4c] = 8'h4d; bridge_bytes[8'h4e] = 8'h03;
      bridge_bytes[8'h60] = 8'h80; bridge_bytes[8'h61] = 8'h80;
      bridge_bytes[8'h62] = 8'h80; bridge_bytes[8'h63] = 8'h80;
      bridge_bytes[8'h69] = 8'h02; bridge_bytes[8'h70] = 8'h80;
      bridge_bytes[8'h71] = 8'h80; bridge_bytes[8'h76] = 8'h0c;
      bridge_bytes[8'h77] = 8'h0c; bridge_bytes[8'h78] = 8'h02;
      bridge_bytes[8'ha0] = 8'h08; bridge_bytes[8'ha8] = 8'h0f;
      ide_bytes[8'h00] = 8'h86; ide_bytes[8'h01] = 8'h80;
      ide_bytes[8'h02] = 8'h30; ide_bytes[8'h03] = 8'h12;
      ide_bytes[8'h04] = 8'h02; ide_bytes[8'h06] = 8'h80;
      ide_bytes[8'h07] = 8'h02; ide_bytes[8'h09] = 8'h80;
      ide_bytes[8'h0a] = 8'h01; ide_bytes[8'h0b] = 8'h01;
      ide_bytes[8'h20] = 8'h01;
      rc_byte = 8'h00;
      faults = 0;
    endfunction

    function logic [4:0] decode_route(logic [7:0] b);
      if (b[7]) return 5'd16;
      return {1'b0, b[3:0]};
    endfunction

    function void note_access(access_t acc);
      cfg_result_t r;
      logic [7:0]  a;
      logic        ide_on;
      r = '0;
      a = acc.addr;
      case (acc.op)
        pcib_pkg::OP_CFG_RD: begin
          if (acc.fn == pcib_pkg::FN_BRIDGE) r.read_data = bridge_bytes[a];
          else if (acc.fn == pcib_pkg::FN_IDE) r.read_data = ide_bytes[a];
          else r.read_data = 8'hff;
        end
        pcib_pkg::OP_CFG_WR: begin
          if (acc.fn == pcib_pkg::FN_BRIDGE) begin
            // ID, class, header type and the 0x0f..0x4b block stay fixed
            if (!(a <= 8'h03 || (a >= 8'h08 && a <= 8'h0b) || (a >= 8'h0e && a <= 8'h4b)))
              bridge_bytes[a] = acc.wdata;
          end else if (acc.fn == pcib_pkg::FN_IDE) begin
            case (a)
              pcib_pkg::ADDR_CMD:
                ide_bytes[a] = (ide_bytes[a] & 8'hfa) | (acc.wdata & 8'h05);
              pcib_pkg::ADDR_STAT_HI:
                ide_bytes[a] = (ide_bytes[a] & 8'hc7) | (acc.wdata & 8'h38);
              pcib_pkg::ADDR_BM_LO:
                ide_bytes[a] = {acc.wdata[7:4], 4'h1};
              pcib_pkg::ADDR_LAT, pcib_pkg::ADDR_BM_HI, pcib_pkg::ADDR_TIM0,
              pcib_pkg::ADDR_TIM1, pcib_pkg::ADDR_TIM2, pcib_pkg::ADDR_TIM3:
                ide_bytes[a] = acc.wdata;
              default: ;
            endcase
          end
        end
        pcib_pkg::OP_RC_RD: r.read_data = rc_byte;
        pcib_pkg::OP_RC_WR: begin
          r.soft_reset = acc.wdata[2];
          r.hard_reset = acc.wdata[2] & acc.wdata[1];
          rc_byte = acc.wdata & 8'hfb;
        end
      endcase
      ide_on    = ide_bytes[pcib_pkg::ADDR_CMD][0];
      r.bm_base = {ide_bytes[pcib_pkg::ADDR_BM_HI], ide_bytes[pcib_pkg::ADDR_BM_LO] & 8'hf0};
      r.bm_en   = ide_on;
      r.pri_en  = ide_on & ide_bytes[pcib_pkg::ADDR_TIM1][7];
      r.sec_en  = ide_on & ide_bytes[pcib_pkg::ADDR_TIM3][7];
      r.irq_a   = decode_route(bridge_bytes[ADDR_IRQ_A]);
      r.irq_b   = decode_route(bridge_bytes[ADDR_IRQ_B]);
      r.irq_c   = decode_route(bridge_bytes[ADDR_IRQ_C]);
      r.irq_d   = decode_route(bridge_bytes[ADDR_IRQ_D]);
      expected_beats.push_back(r);
    endfunction

    function void report(string msg);
      faults++;
      if (faults <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    function void check_beat(logic [55:0] beat);
      cfg_result_t got;
      cfg_result_t want;
      string       diff;
      got = beat[48:0];
      if (expected_beats.size() == 0) begin
        report($sformatf("result beat with nothing expected: %h", beat));
        return;
      end
      want = expected_beats.pop_front();
      diff = "";
      if (got.read_data != want.read_data)
        diff = {diff, $sformatf(" read_data exp %h got %h", want.read_data, got.read_data)};
      if (got.bm_base != want.bm_base)
        diff = {diff, $sformatf(" bm_base exp %h got %h", want.bm_base, got.bm_base)};
      if (got.bm_en != want.bm_en)
        diff = {diff, $sformatf(" bm_en exp %b got %b", want.bm_en, got.bm_en)};
      if (got.pri_en != want.pri_en)
        diff = {diff, $sformatf(" pri_en exp %b got %b", want.pri_en, got.pri_en)};
      if (got.sec_en != want.sec_en)
        diff = {diff, $sformatf(" sec_en exp %b got %b", want.sec_en, got.sec_en)};
      if (got.irq_a != want.irq_a)
        diff = {diff, $sformatf(" irq_a exp %0d got %0d", want.irq_a, got.irq_a)};
      if (got.irq_b != want.irq_b)
        diff = {diff, $sformatf(" irq_b exp %0d got %0d", want.irq_b, got.irq_b)};
      if (got.irq_c != want.irq_c)
        diff = {diff, $sformatf(" irq_c exp %0d got %0d", want.irq_c, got.irq_c)};
      if (got.irq_d != want.irq_d)
        diff = {diff, $sformatf(" irq_d exp %0d got %0d", want.irq_d, got.irq_d)};
      if (got.soft_reset != want.soft_reset)
        diff = {diff, $sformatf(" soft exp %b got %b", want.soft_reset, got.soft_reset)};
      if (got.hard_reset != want.hard_reset)
        diff = {diff, $sformatf(" hard exp %b got %b", want.hard_reset, got.hard_reset)};
      if (diff != "") report({"result mismatch:", diff});
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  logic        hold_req;
  int          idle_pct;
  int          stall_pct;
  int          hold_left;
  int          quiet_cycles;

  cfg_space_scoreboard sb = new();

  pci_bridge_config_space dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // directed opening: boundaries of the read-only ranges, masked IDE bytes,
  // IRQ routes on and off, absent functions and reset-control reads and writes
  access_t directed_seq [] = '{
    '{pcib_pkg::OP_CFG_RD, pcib_pkg::FN_BRIDGE, 8'h00, 8'h00},
    '{pcib_pkg::OP_CFG_RD, pcib_pkg::FN_IDE,    8'h20, 8'hff},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_BRIDGE, 8'h00, 8'hff},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_BRIDGE, 8'h0e, 8'h00},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_BRIDGE, 8'h0f, 8'h55},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_BRIDGE, 8'h4b, 8'haa},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_BRIDGE, 8'h4c, 8'h5a},
    '{pcib_pkg::OP_CFG_RD, pcib_pkg::FN_BRIDGE, 8'h4c, 8'h00},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_BRIDGE, 8'h60, 8'h0b},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_BRIDGE, 8'h63, 8'h7f},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_IDE,    8'h04, 8'hff},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_IDE,    8'h07, 8'hff},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_IDE,    8'h20, 8'hfe},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_IDE,    8'h21, 8'hff},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_IDE,    8'h41, 8'h80},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_IDE,    8'h43, 8'hff},
    '{pcib_pkg::OP_CFG_WR, pcib_pkg::FN_IDE,    8'h00, 8'h00},
    '{pcib_pkg::OP_CFG_RD, pcib_pkg::FN_IDE,    8'h04, 8'h00},
    '{pcib_pkg::OP_CFG_RD, FN_LAST,             8'hff, 8'h00},
    '{pcib_pkg::OP_CFG_WR, 3'd2,                8'h60, 8'h00},
    '{pcib_pkg::OP_RC_WR,  FN_LAST,             8'hff, 8'h06},
    '{pcib_pkg::OP_RC_WR,  pcib_pkg::FN_BRIDGE, 8'h00, 8'h04},
    '{pcib_pkg::OP_RC_WR,  pcib_pkg::FN_IDE,    8'h80, 8'hff},
    '{pcib_pkg::OP_RC_RD,  3'd5,                8'h7f, 8'h00},
    '{pcib_pkg::OP_RC_WR,  pcib_pkg::FN_BRIDGE, 8'h00, 8'h02}
  };

  logic [7:0] hot_addrs [] = '{
    8'h00, 8'h03, 8'h04, 8'h07, 8'h08, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h20, 8'h21,
    8'h40, 8'h41, 8'h42, 8'h43, 8'h4b, 8'h4c, 8'h60, 8'h61, 8'h62, 8'h63, 8'hff
  };

  int idle_by_phase [4]  = '{0, 60, 0, 19};
  int stall_by_phase [4] = '{0, 0, 60, 19};

  task automatic send_access(input access_t acc);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= acc.op;
    in_tdata  <= {5'd0, acc.wdata, acc.addr, acc.fn};
    do @(posedge clk); while (!in_tready);
    sb.note_access(acc);
  endtask

  // result side: check each beat, then decide tready for the next edge
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_beat(out_tdata);
    if (hold_req && hold_left == 0) hold_left = LONG_HOLD;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("pci_bridge_config_space_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    access_t acc;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = pcib_pkg::OP_CFG_RD;
    out_tready   = 1'b0;
    rst_n        = 1'b0;
    hold_req     = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_seq[i]) send_access(directed_seq[i]);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: acc.op = pcib_pkg::OP_CFG_RD;
          4, 5, 6, 7: acc.op = pcib_pkg::OP_CFG_WR;
          8:          acc.op = pcib_pkg::OP_RC_RD;
          default:    acc.op = pcib_pkg::OP_RC_WR;
        endcase
        case ($urandom_range(9))
          0, 1, 2, 3: acc.fn = pcib_pkg::FN_BRIDGE;
          4, 5, 6, 7: acc.fn = pcib_pkg::FN_IDE;
          default:    acc.fn = 3'($urandom_range(7));
        endcase
        if ($urandom_range(1) == 1) acc.addr = hot_addrs[$urandom_range(hot_addrs.size() - 1)];
        else acc.addr = 8'($urandom_range(255));
        acc.wdata = 8'($urandom_range(255));

        // long receiver hold while items keep coming, so the input backs up
        if (ph == 0 && i == 100) hold_req <= 1'b1;
        // sender waits for every outstanding result before going on
        if (ph == 1 && i == 200) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (sb.expected_beats.size() != 0) @(posedge clk);
        end
        send_access(acc);
        if (ph == 0 && i == 100) hold_req <= 1'b0;
      end
    end

    in_tvalid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.faults == 0 && sb.expected_beats.size() == 0)
      $display("pci_bridge_config_space_tb: PASS");
    else
      $display("pci_bridge_config_space_tb: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
src/pcib_pkg.sv
src/pcib_ram.sv
src/pci_bridge_config_space.sv
tb/sv/pci_bridge_config_space_tb.sv
